@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RMQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rmq check failed");

// Check a property on every clock edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rmq check failed");

`endif

@@ hdl/rmq_pkg.sv @@
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int QW = 18;  // rotation entries and quaternion parts
  localparam int PW = 32;  // translation
  localparam int NW = 19;  // sums and differences of two entries

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] p_t;
  typedef logic signed [NW-1:0] num_t;

  // which component comes from the square root
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    branch_t br;
    p_t      tx;
    p_t      ty;
    p_t      tz;
  } tag_t;

  // travels alongside the square root
  typedef struct packed {
    tag_t tag;
    num_t n0;
    num_t n1;
    num_t n2;
  } side_t;

endpackage

@@ hdl/rmq_if.sv @@
`timescale 1ns / 1ps
interface rmq_in_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  q_t   r00, r01, r02, r10, r11, r12, r20, r21, r22;
  p_t   tx, ty, tz;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  q_t   qw, qx, qy, qz;
  p_t   px, py, pz;

  modport source (output valid, qw, qx, qy, qz, px, py, pz, input ready);
  modport sink   (input valid, qw, qx, qy, qz, px, py, pz, output ready);
endinterface

@@ hdl/rmq_front.sv @@
`timescale 1ns / 1ps
module rmq_front #(
  parameter int FB = 16,
  parameter int AW = 20
) (
  input  rmq_pkg::q_t     r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output rmq_pkg::branch_t br,
  output logic [AW-1:0]   arg,
  output rmq_pkg::num_t   n0, n1, n2
);
  import rmq_pkg::*;

  localparam int SAW = AW + 1;
  localparam logic signed [SAW-1:0] ONE = {{(SAW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

  logic signed [SAW-1:0] a00, a11, a22, tr, argw;
  num_t d_w, d_y, d_z, s_xy, s_xz, s_yz;

  always_comb begin
    a00 = SAW'(r00);
    a11 = SAW'(r11);
    a22 = SAW'(r22);
    tr  = a00 + a11 + a22;
    if (tr > 0) begin
      br   = BR_TRACE;
      argw = ONE + tr;
    end else if (r00 > r11 && r00 > r22) begin
      br   = BR_X;
      argw = ONE + a00 - a11 - a22;
    end else if (r11 > r22) begin
      br   = BR_Y;
      argw = ONE + a11 - a00 - a22;
    end else begin
      br   = BR_Z;
      argw = ONE + a22 - a00 - a11;
    end
    // clamp a negative argument to zero
    arg = argw[SAW-1] ? '0 : argw[AW-1:0];
  end

  always_comb begin
    d_w  = NW'(r21) - NW'(r12);
    d_y  = NW'(r02) - NW'(r20);
    d_z  = NW'(r10) - NW'(r01);
    s_xy = NW'(r01) + NW'(r10);
    s_xz = NW'(r02) + NW'(r20);
    s_yz = NW'(r12) + NW'(r21);
    // lanes hold the three off-root components in w, x, y, z order
    case (br)
      BR_TRACE: begin n0 = d_w; n1 = d_y;  n2 = d_z;  end
      BR_X:     begin n0 = d_w; n1 = s_xy; n2 = s_xz; end
      BR_Y:     begin n0 = d_y; n1 = s_xy; n2 = s_yz; end
      BR_Z:     begin n0 = d_z; n1 = s_xz; n2 = s_yz; end
      default:  begin n0 = d_w; n1 = d_y;  n2 = d_z;  end
    endcase
  end
endmodule

@@ hdl/rmq_sqrt_cell.sv @@
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
  parameter int HW = 18,
  parameter int P  = 0,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            vld_i,
  input  logic [HW+1:0]   rem_i,
  input  logic [HW-1:0]   root_i,
  input  logic [2*HW-1:0] x_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [HW+1:0]   rem_o,
  output logic [HW-1:0]   root_o,
  output logic [2*HW-1:0] x_o,
  output logic [SW-1:0]   side_o
);
  logic [HW+1:0] rem_sh, trial;
  logic          ge;

  // bring down the next two radicand bits and try a one for this root bit
  always_comb begin
    rem_sh = {rem_i[HW-1:0], x_i[2*P+1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_o  <= ge ? rem_sh - trial : rem_sh;
      root_o <= {root_i[HW-2:0], ge};
      x_o    <= x_i;
      side_o <= side_i;
    end
  end
endmodule

@@ hdl/rmq_div_cell.sv @@
`timescale 1ns / 1ps
module rmq_div_cell #(
  parameter int FB = 16,
  parameter int HW = 18,
  parameter int J  = 0,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                vld_i,
  input  logic [HW:0]         d_i,
  input  logic [2:0][HW:0]    rem_i,
  input  logic [2:0][FB:0]    q_i,
  input  logic [2:0]          lsb_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [HW:0]         d_o,
  output logic [2:0][HW:0]    rem_o,
  output logic [2:0][FB:0]    q_o,
  output logic [2:0]          lsb_o,
  output logic [SW-1:0]       side_o
);
  logic [2:0][HW+1:0] rs;
  logic [2:0]         ge;

  // one quotient bit per lane; only the first step brings down a numerator bit
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rs[l] = {rem_i[l], (J == 0) ? lsb_i[l] : 1'b0};
      ge[l] = rs[l] >= {1'b0, d_i};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        rem_o[l] <= ge[l] ? (HW + 1)'(rs[l] - {1'b0, d_i}) : rs[l][HW:0];
        q_o[l]   <= {q_i[l][FB-1:0], ge[l]};
      end
      d_o    <= d_i;
      lsb_o  <= lsb_i;
      side_o <= side_i;
    end
  end
endmodule

@@ hdl/rotation_matrix_to_quaternion_core.sv @@
`timescale 1ns / 1ps
// Rotation matrix to quaternion (Shepperd's method) with translation pass-through.
// Each item carries nine rotation entries and a translation; the result item
// carries the quaternion (w,x,y,z), saturated to +-1.0 with FRAC_BITS fraction
// bits, and the translation unchanged. One item is taken every clock cycle while
// the output is not stalled. Each item passes the input register, the front
// register, the square-root chain (one root bit per cell, where HW is the root
// width ceil((max(FRAC_BITS,18) + 2 + FRAC_BITS) / 2)), the divider set-up
// register, the divide chain (one quotient bit per cell for all three lanes)
// and the output register. The whole pipeline stalls only while a finished
// item waits at the output and the sink is not ready. A degenerate input
// (root of zero) gives a zero quaternion.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = 16
) (
  input logic     clk,
  input logic     rst,
  rmq_in_if.sink  pose_in,
  rmq_out_if.source pose_out
);
  import rmq_pkg::*;

  localparam int FB  = FRAC_BITS;
  localparam int AW  = ((FB > QW) ? FB : QW) + 2;     // clamped argument width
  localparam int XW  = AW + FB;                       // radicand width
  localparam int HW  = (XW + 1) / 2;                  // root width
  localparam int CW  = (NW > HW + 2) ? NW : HW + 2;   // overflow compare width
  localparam int GW  = (HW > FB + 2) ? HW : FB + 2;   // diagonal compare width
  localparam int EW  = (FB + 2 > QW) ? FB + 2 : QW;   // signed result width
  localparam int SSW = $bits(side_t);
  localparam int DSW = $bits(tag_t) + 1 + 3 + 3 + FB + 1;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  // advance every stage unless a finished item is stuck at the output
  logic adv;
  logic out_vld;
  assign adv           = !out_vld || pose_out.ready;
  assign pose_in.ready = adv;

  // input register
  logic v1;
  q_t   i00, i01, i02, i10, i11, i12, i20, i21, i22;
  p_t   itx, ity, itz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pose_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i00 <= pose_in.r00; i01 <= pose_in.r01; i02 <= pose_in.r02;
      i10 <= pose_in.r10; i11 <= pose_in.r11; i12 <= pose_in.r12;
      i20 <= pose_in.r20; i21 <= pose_in.r21; i22 <= pose_in.r22;
      itx <= pose_in.tx;  ity <= pose_in.ty;  itz <= pose_in.tz;
    end
  end

  // branch choice, argument and numerators
  branch_t       f_br;
  logic [AW-1:0] f_arg;
  num_t          f_n0, f_n1, f_n2;

  rmq_front #(.FB(FB), .AW(AW)) u_front (
    .r00(i00), .r01(i01), .r02(i02), .r10(i10), .r11(i11), .r12(i12),
    .r20(i20), .r21(i21), .r22(i22),
    .br(f_br), .arg(f_arg), .n0(f_n0), .n1(f_n1), .n2(f_n2)
  );

  logic          v2;
  logic [AW-1:0] arg2;
  side_t         side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arg2          <= f_arg;
      side2.tag.br  <= f_br;
      side2.tag.tx  <= itx;
      side2.tag.ty  <= ity;
      side2.tag.tz  <= itz;
      side2.n0      <= f_n0;
      side2.n1      <= f_n1;
      side2.n2      <= f_n2;
    end
  end

  // square-root chain: cell i settles root bit HW-1-i
  logic [HW:0]               s_vld;
  logic [HW:0][HW+1:0]       s_rem;
  logic [HW:0][HW-1:0]       s_root;
  logic [HW:0][2*HW-1:0]     s_x;
  logic [HW:0][SSW-1:0]      s_side;

  assign s_vld[0]  = v2;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_x[0]    = (2*HW)'({arg2, {FB{1'b0}}});
  assign s_side[0] = side2;

  for (genvar i = 0; i < HW; i++) begin : g_sqrt
    rmq_sqrt_cell #(.HW(HW), .P(HW - 1 - i), .SW(SSW)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .vld_i(s_vld[i]), .rem_i(s_rem[i]), .root_i(s_root[i]), .x_i(s_x[i]),
      .side_i(s_side[i]),
      .vld_o(s_vld[i+1]), .rem_o(s_rem[i+1]), .root_o(s_root[i+1]), .x_o(s_x[i+1]),
      .side_o(s_side[i+1])
    );
  end

  // divider set-up: magnitudes, overflow flags and the diagonal part
  side_t         sq_side;
  logic [HW-1:0] h;
  num_t          nn [3];
  logic [2:0]    m_neg_next, m_sat_next, m_lsb_next;
  logic [2:0][HW:0] m_rem_next;
  logic [GW-1:0] hh;
  logic [FB:0]   m_diag_next;
  logic [NW-1:0] mag;
  logic [CW-1:0] mag_c;

  assign sq_side = s_side[HW];
  assign h       = s_root[HW];

  always_comb begin
    nn[0] = sq_side.n0;
    nn[1] = sq_side.n1;
    nn[2] = sq_side.n2;
    mag   = '0;
    mag_c = '0;
    for (int l = 0; l < 3; l++) begin
      m_neg_next[l] = nn[l][NW-1];
      mag           = nn[l][NW-1] ? NW'(-nn[l]) : nn[l];
      mag_c         = CW'(mag);
      // quotient of two or more: saturate, the chain result is ignored
      m_sat_next[l] = mag_c >= (CW'(h) << 2);
      m_rem_next[l] = (HW + 1)'(mag_c >> 1);
      m_lsb_next[l] = mag[0];
    end
    hh          = GW'(h >> 1);
    m_diag_next = (hh > GW'(ONE)) ? ONE : hh[FB:0];
  end

  logic             vm;
  logic [HW:0]      m_d;
  logic [2:0][HW:0] m_rem;
  logic [2:0]       m_lsb;
  logic [DSW-1:0]   m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= s_vld[HW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_d    <= {h, 1'b0};
      m_rem  <= m_rem_next;
      m_lsb  <= m_lsb_next;
      m_side <= {sq_side.tag, (h == '0), m_neg_next, m_sat_next, m_diag_next};
    end
  end

  // divide chain: cell j settles quotient bit FB-j of all three lanes
  logic [FB+1:0]             d_vld;
  logic [FB+1:0][HW:0]       d_d;
  logic [FB+1:0][2:0][HW:0]  d_rem;
  logic [FB+1:0][2:0][FB:0]  d_q;
  logic [FB+1:0][2:0]        d_lsb;
  logic [FB+1:0][DSW-1:0]    d_side;

  assign d_vld[0]  = vm;
  assign d_d[0]    = m_d;
  assign d_rem[0]  = m_rem;
  assign d_q[0]    = '0;
  assign d_lsb[0]  = m_lsb;
  assign d_side[0] = m_side;

  for (genvar j = 0; j <= FB; j++) begin : g_div
    rmq_div_cell #(.FB(FB), .HW(HW), .J(j), .SW(DSW)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .vld_i(d_vld[j]), .d_i(d_d[j]), .rem_i(d_rem[j]), .q_i(d_q[j]),
      .lsb_i(d_lsb[j]), .side_i(d_side[j]),
      .vld_o(d_vld[j+1]), .d_o(d_d[j+1]), .rem_o(d_rem[j+1]), .q_o(d_q[j+1]),
      .lsb_o(d_lsb[j+1]), .side_o(d_side[j+1])
    );
  end

  // result assembly: clamp, apply signs and place the diagonal part
  tag_t             e_tag;
  logic             e_hz;
  logic [2:0]       e_neg, e_sat;
  logic [FB:0]      e_diag, mq;
  logic [2:0][EW-1:0] lv;
  logic [EW-1:0]    qd, sv, vw, vx, vy, vz;

  assign {e_tag, e_hz, e_neg, e_sat, e_diag} = d_side[FB+1];

  always_comb begin
    mq = '0;
    sv = '0;
    for (int l = 0; l < 3; l++) begin
      mq    = (e_sat[l] || d_q[FB+1][l] > ONE) ? ONE : d_q[FB+1][l];
      sv    = EW'(mq);
      lv[l] = e_neg[l] ? EW'(-sv) : sv;
    end
    qd = EW'(e_diag);
    case (e_tag.br)
      BR_TRACE: begin vw = qd;    vx = lv[0]; vy = lv[1]; vz = lv[2]; end
      BR_X:     begin vw = lv[0]; vx = qd;    vy = lv[1]; vz = lv[2]; end
      BR_Y:     begin vw = lv[0]; vx = lv[1]; vy = qd;    vz = lv[2]; end
      BR_Z:     begin vw = lv[0]; vx = lv[1]; vy = lv[2]; vz = qd;    end
      default:  begin vw = qd;    vx = lv[0]; vy = lv[1]; vz = lv[2]; end
    endcase
    // degenerate root: drop the whole quaternion to zero
    if (e_hz) begin
      vw = '0; vx = '0; vy = '0; vz = '0;
    end
  end

  // output register; holds its item until the sink takes it
  q_t oqw, oqx, oqy, oqz;
  p_t opx, opy, opz;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= d_vld[FB+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oqw <= q_t'(vw[QW-1:0]);
      oqx <= q_t'(vx[QW-1:0]);
      oqy <= q_t'(vy[QW-1:0]);
      oqz <= q_t'(vz[QW-1:0]);
      opx <= e_tag.tx;
      opy <= e_tag.ty;
      opz <= e_tag.tz;
    end
  end

  assign pose_out.valid = out_vld;
  assign pose_out.qw    = oqw;
  assign pose_out.qx    = oqx;
  assign pose_out.qy    = oqy;
  assign pose_out.qz    = oqz;
  assign pose_out.px    = opx;
  assign pose_out.py    = opy;
  assign pose_out.pz    = opz;
endmodule

@@ hdl/rmq_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmq_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input rmq_pkg::q_t qw,
  input rmq_pkg::q_t qx,
  input rmq_pkg::q_t qy,
  input rmq_pkg::q_t qz,
  input rmq_pkg::p_t px
);
  import rmq_pkg::*;

  localparam bit CHK = (FRAC_BITS <= 16);
  localparam int LIM = CHK ? (1 << FRAC_BITS) : 0;

  // input side stalls exactly when a result is held
  `RMQ_ASSERT(a_ready_follows, clk, rst, in_ready == (!out_valid || out_ready))
  `RMQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `RMQ_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(qw) && $stable(px))
  // unit range when 1.0 fits the field
  `RMQ_ASSERT(a_unit_range, clk, rst, (out_valid && CHK) |-> (qw <= LIM && qw >= -LIM && qx <= LIM && qx >= -LIM && qy <= LIM && qy >= -LIM && qz <= LIM && qz >= -LIM))
endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
  .clk(clk), .rst(rst), .in_ready(pose_in.ready),
  .out_valid(pose_out.valid), .out_ready(pose_out.ready),
  .qw(pose_out.qw), .qx(pose_out.qx), .qy(pose_out.qy), .qz(pose_out.qz),
  .px(pose_out.px)
);

@@ test/rotation_matrix_to_quaternion_core_test.sv @@
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core_test;
  import rmq_pkg::*;

  localparam int FRAC     = 16;
  localparam int ONE      = 1 << FRAC;
  localparam q_t Q_ONE    = q_t'(ONE);
  localparam q_t Q_NEG    = q_t'(-ONE);
  localparam int N_RANDOM = 750;
  localparam int HOLD_LEN = 300;   // long receiver hold-off, well over the pipeline depth
  localparam int DRAIN    = 80;    // longer than the pipeline at the default width

  // One input item: nine rotation entries and a translation.
  typedef struct {
    q_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
    p_t tx, ty, tz;
  } pose_t;

  // One result item: quaternion and the translation carried through.
  typedef struct {
    q_t qw, qx, qy, qz;
    p_t px, py, pz;
  } quat_t;

  // Holds the expected quaternions in arrival order and checks results against them.
  class quat_scoreboard;
    quat_t pending[$];
    int    mismatches;
    int    checked;
    int    branch_seen[4];

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   -= res + bitv;
          res  = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint clamp_one(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
    endfunction

    // n / (2h), truncated toward zero, clamped to +-1.0
    function longint scaled_quotient(longint n, longint unsigned h);
      longint unsigned mag, q;
      mag = (n < 0) ? -n : n;
      q   = (mag << FRAC) / (2 * h);
      if (q > ONE) q = ONE;
      return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function quat_t to_quaternion(pose_t p);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg, diag;
      longint w, x, y, z;
      longint unsigned h;
      branch_t br;
      quat_t e;
      a00 = longint'(p.r00); a01 = longint'(p.r01); a02 = longint'(p.r02);
      a10 = longint'(p.r10); a11 = longint'(p.r11); a12 = longint'(p.r12);
      a20 = longint'(p.r20); a21 = longint'(p.r21); a22 = longint'(p.r22);
      tr = a00 + a11 + a22;
      if (tr > 0) begin
        br = BR_TRACE; arg = ONE + tr;
      end else if (a00 > a11 && a00 > a22) begin
        br = BR_X; arg = ONE + a00 - a11 - a22;
      end else if (a11 > a22) begin
        br = BR_Y; arg = ONE + a11 - a00 - a22;
      end else begin
        br = BR_Z; arg = ONE + a22 - a00 - a11;
      end
      branch_seen[br]++;
      if (arg < 0) arg = 0;
      h = root_floor(longint'(arg) << FRAC);
      w = 0; x = 0; y = 0; z = 0;
      if (h != 0) begin
        diag = clamp_one(longint'(h >> 1));
        case (br)
          BR_TRACE: begin
            w = diag;
            x = scaled_quotient(a21 - a12, h);
            y = scaled_quotient(a02 - a20, h);
            z = scaled_quotient(a10 - a01, h);
          end
          BR_X: begin
            w = scaled_quotient(a21 - a12, h);
            x = diag;
            y = scaled_quotient(a01 + a10, h);
            z = scaled_quotient(a02 + a20, h);
          end
          BR_Y: begin
            w = scaled_quotient(a02 - a20, h);
            x = scaled_quotient(a01 + a10, h);
            y = diag;
            z = scaled_quotient(a12 + a21, h);
          end
          default: begin
            w = scaled_quotient(a10 - a01, h);
            x = scaled_quotient(a02 + a20, h);
            y = scaled_quotient(a12 + a21, h);
            z = diag;
          end
        endcase
      end
      e.qw = q_t'(w); e.qx = q_t'(x); e.qy = q_t'(y); e.qz = q_t'(z);
      e.px = p.tx; e.py = p.ty; e.pz = p.tz;
      return e;
    endfunction

    function void note_pose(pose_t p);
      pending.push_back(to_quaternion(p));
    endfunction

    function void field(string name, longint exp, longint act);
      if (exp != act) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check_quat(quat_t got);
      quat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: result item with nothing expected, actual qw %0d px %0d",
                 $time, got.qw, got.px);
        return;
      end
      e = pending.pop_front();
      checked++;
      field("qw", e.qw, got.qw);
      field("qx", e.qx, got.qx);
      field("qy", e.qy, got.qy);
      field("qz", e.qz, got.qz);
      field("px", e.px, got.px);
      field("py", e.py, got.py);
      field("pz", e.pz, got.pz);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_in_if  pose_in ();
  rmq_out_if pose_out ();

  rotation_matrix_to_quaternion_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .pose_in  (pose_in.sink),
    .pose_out (pose_out.source)
  );

  always #10 clk = ~clk;

  quat_scoreboard sb = new();

  int send_idle_pct = 0;   // chance in a hundred that the sender idles before an item
  int recv_stall_pct = 0;  // chance in a hundred that the receiver drops ready
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  // Receiver: drive ready at random; run the long hold-off once when asked,
  // counting its own cycles so the sender keeps offering items meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      pose_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      pose_out.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_LEN;
      pose_out.ready <= 1'b0;
    end else begin
      pose_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every accepted result item; values are those held before the edge.
  always @(posedge clk) begin
    quat_t got;
    if (!rst && pose_out.valid && pose_out.ready) begin
      got.qw = pose_out.qw; got.qx = pose_out.qx;
      got.qy = pose_out.qy; got.qz = pose_out.qz;
      got.px = pose_out.px; got.py = pose_out.py; got.pz = pose_out.pz;
      sb.check_quat(got);
    end
  end

  // Offer one item, idling first at random, and hold it until accepted.
  task automatic send_pose(pose_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      pose_in.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pose_in.valid <= 1'b1;
    pose_in.r00 <= p.r00; pose_in.r01 <= p.r01; pose_in.r02 <= p.r02;
    pose_in.r10 <= p.r10; pose_in.r11 <= p.r11; pose_in.r12 <= p.r12;
    pose_in.r20 <= p.r20; pose_in.r21 <= p.r21; pose_in.r22 <= p.r22;
    pose_in.tx <= p.tx; pose_in.ty <= p.ty; pose_in.tz <= p.tz;
    do @(posedge clk); while (!pose_in.ready);
    sb.note_pose(p);
  endtask

  function automatic pose_t diag_pose(int d0, int d1, int d2);
    pose_t p;
    p.r00 = q_t'(d0); p.r01 = '0;        p.r02 = '0;
    p.r10 = '0;       p.r11 = q_t'(d1);  p.r12 = '0;
    p.r20 = '0;       p.r21 = '0;        p.r22 = q_t'(d2);
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    return p;
  endfunction

  // Entry in [-1.0, +1.0], leaning on the extremes now and then.
  function automatic q_t rand_entry();
    case ($urandom_range(9))
      0: return Q_NEG;
      1: return Q_ONE;
      2: return q_t'(int'($urandom_range(0, 8)) - 4);
      default: return q_t'(int'($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic q_t nudge(int v);
    int n;
    n = v + int'($urandom_range(0, 400)) - 200;
    if (n > ONE) n = ONE;
    if (n < -ONE) n = -ONE;
    return q_t'(n);
  endfunction

  // Mostly signed permutation matrices (proper rotations among them) with
  // small noise, which hit every branch near its boundaries; the rest are
  // arbitrary entries.
  function automatic pose_t rand_pose();
    pose_t p;
    int m[9];
    int perm, a, b, c;
    if ($urandom_range(99) < 60) begin
      perm = $urandom_range(5);
      a = perm / 2;
      b = (a + 1 + (perm % 2)) % 3;
      c = 3 - a - b;
      foreach (m[i]) m[i] = 0;
      m[a]     = $urandom_range(1) ? ONE : -ONE;
      m[3 + b] = $urandom_range(1) ? ONE : -ONE;
      m[6 + c] = $urandom_range(1) ? ONE : -ONE;
      p.r00 = nudge(m[0]); p.r01 = nudge(m[1]); p.r02 = nudge(m[2]);
      p.r10 = nudge(m[3]); p.r11 = nudge(m[4]); p.r12 = nudge(m[5]);
      p.r20 = nudge(m[6]); p.r21 = nudge(m[7]); p.r22 = nudge(m[8]);
    end else begin
      p.r00 = rand_entry(); p.r01 = rand_entry(); p.r02 = rand_entry();
      p.r10 = rand_entry(); p.r11 = rand_entry(); p.r12 = rand_entry();
      p.r20 = rand_entry(); p.r21 = rand_entry(); p.r22 = rand_entry();
    end
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    return p;
  endfunction

  initial begin
    pose_t p;
    pose_t directed[$];
    pose_in.valid = 1'b0;
    pose_in.r00 = '0; pose_in.r01 = '0; pose_in.r02 = '0;
    pose_in.r10 = '0; pose_in.r11 = '0; pose_in.r12 = '0;
    pose_in.r20 = '0; pose_in.r21 = '0; pose_in.r22 = '0;
    pose_in.tx = '0; pose_in.ty = '0; pose_in.tz = '0;
    pose_out.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: each branch, ties between diagonal entries, zero and full-scale
    // matrices, off-diagonal extremes and translation extremes.
    directed.push_back(diag_pose(ONE, ONE, ONE));        // identity, trace branch
    directed.push_back(diag_pose(ONE, -ONE, -ONE));      // half turn about x
    directed.push_back(diag_pose(-ONE, ONE, -ONE));      // half turn about y
    directed.push_back(diag_pose(-ONE, -ONE, ONE));      // half turn about z
    directed.push_back(diag_pose(0, 0, 0));              // trace zero, all tied
    directed.push_back(diag_pose(-ONE, -ONE, -ONE));     // all tied, negative
    directed.push_back(diag_pose(0, 0, -ONE));           // tie falls to y
    directed.push_back(diag_pose(-ONE, 0, 0));           // tie falls to z
    directed.push_back(diag_pose(1, 0, 0));              // smallest positive trace
    p = diag_pose(0, 0, ONE);                            // quarter turn about z
    p.r01 = Q_NEG; p.r10 = Q_ONE; p.r22 = Q_ONE; p.r00 = '0; p.r11 = '0;
    directed.push_back(p);
    p = diag_pose(1, 0, 0);                              // off-diagonals at full scale
    p.r21 = Q_ONE; p.r12 = Q_NEG; p.r02 = Q_ONE; p.r20 = Q_NEG; p.r10 = Q_ONE;
    p.r01 = Q_NEG;
    directed.push_back(p);
    p = diag_pose(-ONE, -ONE, -ONE);                     // sums at full scale, z branch
    p.r01 = Q_ONE; p.r02 = Q_ONE; p.r10 = Q_ONE; p.r12 = Q_ONE; p.r20 = Q_ONE;
    p.r21 = Q_ONE;
    directed.push_back(p);
    p = diag_pose(0, -ONE, -ONE);                        // x branch, negative sums
    p.r01 = Q_NEG; p.r10 = Q_NEG; p.r02 = Q_NEG; p.r20 = Q_NEG; p.r21 = Q_NEG;
    p.r12 = Q_ONE;
    directed.push_back(p);
    p = diag_pose(ONE, ONE, ONE);                        // translation extremes
    p.tx = 32'h7fff_ffff; p.ty = 32'h8000_0000; p.tz = 32'hffff_ffff;
    directed.push_back(p);
    p = diag_pose(-ONE, ONE, ONE);
    p.tx = 0; p.ty = 32'h5555_5555; p.tz = 32'haaaa_aaaa;
    directed.push_back(p);
    foreach (directed[i]) send_pose(directed[i]);

    // Random: no idling (with the long hold-off), then idling sender,
    // stalling receiver, and both together.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) send_pose(rand_pose());
    end
    pose_in.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Checked %0d result items; branches taken: trace %0d, x %0d, y %0d, z %0d.",
             sb.checked, sb.branch_seen[BR_TRACE], sb.branch_seen[BR_X],
             sb.branch_seen[BR_Y], sb.branch_seen[BR_Z]);
    $display("Phases covered full rate, a long output hold-off, and random gaps on both sides.");
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4000000;
    $display("Timeout with %0d result items outstanding", sb.pending.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
